// ----- sv/rounded_corner_coverage_blend_top_assert.svh -----
// assertion macros shared by the checker of the rounded corner coverage blend
`ifndef ROUNDED_CORNER_COVERAGE_BLEND_TOP_ASSERT_SVH
`define ROUNDED_CORNER_COVERAGE_BLEND_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RCB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcb check failed");

// next-cycle implication, checked outside reset
`define RCB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcb check failed");

`endif

// ----- sv/rcb_pkg.sv -----
// shared types, constants and the root table function of the coverage blend
package rcb_pkg;

    localparam int RCB_MAX_CORNER_RADIUS = 8;

    localparam int COORD_W  = 14;
    localparam int SIZE_W   = 13;
    localparam int RADIUS_W = 4;
    localparam int PIXEL_W  = 32;
    localparam int COV_W    = 8;
    localparam int ROOT_W   = 10;
    localparam int DIST_W   = 20;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int S_DATA_W   = 96;
    localparam int M_DATA_W   = 40;

    localparam logic [COV_W-1:0] COV_FULL     = 8'hFF;
    localparam logic [COV_W-1:0] COV_NONE     = 8'h00;
    localparam logic [7:0]       ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [2:0] {
        REG_RECT_LEFT     = 3'd0,
        REG_RECT_TOP      = 3'd1,
        REG_RECT_WIDTH    = 3'd2,
        REG_RECT_HEIGHT   = 3'd3,
        REG_CORNER_RADIUS = 3'd4
    } rcb_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] rect_left;
        logic signed [COORD_W-1:0] rect_top;
        logic [SIZE_W-1:0]         rect_width;
        logic [SIZE_W-1:0]         rect_height;
        logic [RADIUS_W-1:0]       corner_radius;
    } rcb_cfg_t;

    // round(4*sqrt(k)): count of v with (2v+1)^2 <= 64k
    function automatic logic [ROOT_W-1:0] root_entry(input int k);
        int v;
        v = 0;
        for (int i = 0; i < 1024; i++) begin
            if ((2 * i + 1) * (2 * i + 1) <= 64 * k) begin
                v = i + 1;
            end
        end
        return ROOT_W'(v);
    endfunction

endpackage

// ----- sv/rcb_root_rom.sv -----
// square root rom with registered read port
module rcb_root_rom
    import rcb_pkg::*;
#(
    parameter int DEPTH  = 513,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [ROOT_W-1:0] rd_data
);

    logic [ROOT_W-1:0] rom_w [DEPTH];
    logic [ROOT_W-1:0] rd_data_reg;

    for (genvar g = 0; g < DEPTH; g++) begin : g_rom
        assign rom_w[g] = root_entry(g);
    end

    always_ff @(posedge aclk) begin
        if (rd_en && (int'(rd_addr) < DEPTH)) begin
            rd_data_reg <= rom_w[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/rcb_dist.sv -----
// five stage distance and coverage pipeline
module rcb_dist
    import rcb_pkg::*;
#(
    parameter int MAX_CORNER_RADIUS = RCB_MAX_CORNER_RADIUS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rcb_cfg_t                  cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] in_x,
    input  logic signed [COORD_W-1:0] in_y,
    input  logic [PIXEL_W-1:0]        in_dest,
    input  logic [PIXEL_W-1:0]        in_src,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [COV_W-1:0]          out_cov,
    output logic [PIXEL_W-1:0]        out_dest,
    output logic [PIXEL_W-1:0]        out_src
);

    localparam int Q_LIMIT    = 2 * MAX_CORNER_RADIUS;
    localparam int DEPTH      = 2 * Q_LIMIT * Q_LIMIT + 1;
    localparam int AW         = $clog2(DEPTH);
    localparam int QW         = $clog2(DEPTH + 1);
    localparam int SQW        = 2 * QW;
    localparam int KW         = SQW + 1;
    localparam int RW         = $clog2(MAX_CORNER_RADIUS + 1);
    localparam int FAR_DIST   = 8 * Q_LIMIT;
    localparam int NUM_STAGES = 5;

    logic [NUM_STAGES:1]   valid_reg;
    logic [NUM_STAGES:1]   valid_in;
    logic [NUM_STAGES+1:1] stage_ready;

    always_comb begin
        stage_ready[NUM_STAGES+1] = out_ready;
        for (int i = NUM_STAGES; i >= 1; i--) begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    assign valid_in = {valid_reg[NUM_STAGES-1:1], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 1; i <= NUM_STAGES; i++) begin
                if (stage_ready[i]) begin
                    valid_reg[i] <= valid_in[i];
                end
            end
        end
    end

    assign in_ready  = stage_ready[1];
    assign out_valid = valid_reg[NUM_STAGES];

    // stage 1: absolute half-pixel offsets from the rectangle center
    logic signed [16:0] pos_x, pos_y, ctr_x, ctr_y, diff_x, diff_y;
    logic [15:0]        ax_next, ay_next;
    logic [RW-1:0]      r_next;
    logic [15:0]        s1_ax_reg, s1_ay_reg;
    logic [RW-1:0]      s1_r_reg;
    logic [PIXEL_W-1:0] s1_dest_reg, s1_src_reg;

    always_comb begin
        pos_x  = (17'(in_x) <<< 1) + 17'sd1;
        pos_y  = (17'(in_y) <<< 1) + 17'sd1;
        ctr_x  = (17'(cfg.rect_left) <<< 1) + signed'(17'(cfg.rect_width));
        ctr_y  = (17'(cfg.rect_top) <<< 1) + signed'(17'(cfg.rect_height));
        diff_x = pos_x - ctr_x;
        diff_y = pos_y - ctr_y;
        ax_next = diff_x[16] ? 16'(-diff_x) : 16'(diff_x);
        ay_next = diff_y[16] ? 16'(-diff_y) : 16'(diff_y);
        if (int'(cfg.corner_radius) > MAX_CORNER_RADIUS) begin
            r_next = RW'(MAX_CORNER_RADIUS);
        end else begin
            r_next = RW'(cfg.corner_radius);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[1]) begin
            s1_ax_reg   <= ax_next;
            s1_ay_reg   <= ay_next;
            s1_r_reg    <= r_next;
            s1_dest_reg <= in_dest;
            s1_src_reg  <= in_src;
        end
    end

    // stage 2: offsets past the straight spans, inner distance, clamping
    logic signed [16:0]       span_x, span_y, qx, qy, qmax;
    logic signed [DIST_W-1:0] d_in_next;
    logic                     inside_next, far_next;
    logic [QW-1:0]            qxc_next, qyc_next;
    logic [QW-1:0]            s2_qx_reg, s2_qy_reg;
    logic                     s2_inside_reg, s2_far_reg;
    logic signed [DIST_W-1:0] s2_d_in_reg;
    logic [RW-1:0]            s2_r_reg;
    logic [PIXEL_W-1:0]       s2_dest_reg, s2_src_reg;

    always_comb begin
        span_x = signed'(17'(cfg.rect_width)) - signed'(17'({s1_r_reg, 1'b0}));
        span_y = signed'(17'(cfg.rect_height)) - signed'(17'({s1_r_reg, 1'b0}));
        qx     = signed'(17'(s1_ax_reg)) - span_x;
        qy     = signed'(17'(s1_ay_reg)) - span_y;
        qmax   = (qx > qy) ? qx : qy;
        inside_next = (qx <= 17'sd0) && (qy <= 17'sd0);
        d_in_next   = (DIST_W'(qmax) <<< 2) - signed'(DIST_W'({s1_r_reg, 3'b000}));
        far_next    = (int'(qx) >= DEPTH) || (int'(qy) >= DEPTH);
        qxc_next    = qx[16] ? '0 : qx[QW-1:0];
        qyc_next    = qy[16] ? '0 : qy[QW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[2]) begin
            s2_qx_reg     <= qxc_next;
            s2_qy_reg     <= qyc_next;
            s2_inside_reg <= inside_next;
            s2_far_reg    <= far_next;
            s2_d_in_reg   <= d_in_next;
            s2_r_reg      <= s1_r_reg;
            s2_dest_reg   <= s1_dest_reg;
            s2_src_reg    <= s1_src_reg;
        end
    end

    // stage 3: squares
    logic [SQW-1:0]           sqx_next, sqy_next;
    logic [SQW-1:0]           s3_sqx_reg, s3_sqy_reg;
    logic                     s3_inside_reg, s3_far_reg;
    logic signed [DIST_W-1:0] s3_d_in_reg;
    logic [RW-1:0]            s3_r_reg;
    logic [PIXEL_W-1:0]       s3_dest_reg, s3_src_reg;

    assign sqx_next = SQW'(s2_qx_reg) * SQW'(s2_qx_reg);
    assign sqy_next = SQW'(s2_qy_reg) * SQW'(s2_qy_reg);

    always_ff @(posedge aclk) begin
        if (stage_ready[3]) begin
            s3_sqx_reg    <= sqx_next;
            s3_sqy_reg    <= sqy_next;
            s3_inside_reg <= s2_inside_reg;
            s3_far_reg    <= s2_far_reg;
            s3_d_in_reg   <= s2_d_in_reg;
            s3_r_reg      <= s2_r_reg;
            s3_dest_reg   <= s2_dest_reg;
            s3_src_reg    <= s2_src_reg;
        end
    end

    // stage 4: table index and rom read
    logic [KW-1:0]            k_sum;
    logic                     far4_next;
    logic [ROOT_W-1:0]        root_data;
    logic                     s4_inside_reg, s4_far_reg;
    logic signed [DIST_W-1:0] s4_d_in_reg;
    logic [RW-1:0]            s4_r_reg;
    logic [PIXEL_W-1:0]       s4_dest_reg, s4_src_reg;

    assign k_sum     = KW'(s3_sqx_reg) + KW'(s3_sqy_reg);
    assign far4_next = s3_far_reg || (int'(k_sum) >= DEPTH);

    rcb_root_rom #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_rom (
        .aclk    (aclk),
        .rd_en   (stage_ready[4]),
        .rd_addr (k_sum[AW-1:0]),
        .rd_data (root_data)
    );

    always_ff @(posedge aclk) begin
        if (stage_ready[4]) begin
            s4_inside_reg <= s3_inside_reg;
            s4_far_reg    <= far4_next;
            s4_d_in_reg   <= s3_d_in_reg;
            s4_r_reg      <= s3_r_reg;
            s4_dest_reg   <= s3_dest_reg;
            s4_src_reg    <= s3_src_reg;
        end
    end

    // stage 5: distance select and coverage ramp
    logic signed [DIST_W-1:0] d_corner, edge_dist;
    logic [COV_W-1:0]         cov_next;
    logic [COV_W-1:0]         s5_cov_reg;
    logic [PIXEL_W-1:0]       s5_dest_reg, s5_src_reg;

    always_comb begin
        d_corner = signed'(DIST_W'(root_data)) - signed'(DIST_W'({s4_r_reg, 3'b000}));
        if (s4_far_reg) begin
            edge_dist = DIST_W'(FAR_DIST);
        end else if (s4_inside_reg) begin
            edge_dist = s4_d_in_reg;
        end else begin
            edge_dist = d_corner;
        end
        if (edge_dist <= -4) begin
            cov_next = COV_FULL;
        end else if (edge_dist >= 4) begin
            cov_next = COV_NONE;
        end else begin
            // one pixel ramp, 32 per eighth pixel
            cov_next = COV_W'((DIST_W'(4) - edge_dist) <<< 5);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[5]) begin
            s5_cov_reg  <= cov_next;
            s5_dest_reg <= s4_dest_reg;
            s5_src_reg  <= s4_src_reg;
        end
    end

    assign out_cov  = s5_cov_reg;
    assign out_dest = s5_dest_reg;
    assign out_src  = s5_src_reg;

endmodule

// ----- sv/rcb_blend.sv -----
// two stage alpha blend of source over destination
module rcb_blend
    import rcb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [COV_W-1:0]   in_cov,
    input  logic [PIXEL_W-1:0] in_dest,
    input  logic [PIXEL_W-1:0] in_src,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PIXEL_W-1:0] out_pixel,
    output logic [COV_W-1:0]   out_cov
);

    localparam int NUM_STAGES = 2;

    logic [NUM_STAGES:1]   valid_reg;
    logic [NUM_STAGES:1]   valid_in;
    logic [NUM_STAGES+1:1] stage_ready;

    always_comb begin
        stage_ready[NUM_STAGES+1] = out_ready;
        for (int i = NUM_STAGES; i >= 1; i--) begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    assign valid_in = {valid_reg[NUM_STAGES-1:1], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 1; i <= NUM_STAGES; i++) begin
                if (stage_ready[i]) begin
                    valid_reg[i] <= valid_in[i];
                end
            end
        end
    end

    assign in_ready  = stage_ready[1];
    assign out_valid = valid_reg[NUM_STAGES];

    // stage 1: weighted sums per channel, rounding bias included
    logic [15:0]        mix_next [3];
    logic [15:0]        mix_reg  [3];
    logic [COV_W-1:0]   s1_cov_reg;
    logic [PIXEL_W-1:0] s1_dest_reg, s1_src_reg;

    always_comb begin
        logic [7:0] weight;
        weight = 8'd255 - in_cov;
        for (int c = 0; c < 3; c++) begin
            mix_next[c] = ({8'b0, in_src[8*c +: 8]} * {8'b0, in_cov})
                        + ({8'b0, in_dest[8*c +: 8]} * {8'b0, weight})
                        + 16'd127;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[1]) begin
            for (int c = 0; c < 3; c++) begin
                mix_reg[c] <= mix_next[c];
            end
            s1_cov_reg  <= in_cov;
            s1_dest_reg <= in_dest;
            s1_src_reg  <= in_src;
        end
    end

    // stage 2: divide by 255 and pick the result
    logic [7:0]         chan [3];
    logic [PIXEL_W-1:0] pixel_next;
    logic [PIXEL_W-1:0] pixel_reg;
    logic [COV_W-1:0]   cov_reg;

    always_comb begin
        logic [16:0] t;
        t = '0;
        for (int c = 0; c < 3; c++) begin
            // exact n/255 for n below 65535
            t = 17'(mix_reg[c]) + 17'd1 + 17'(mix_reg[c][15:8]);
            chan[c] = t[15:8];
        end
        if (s1_cov_reg == COV_NONE) begin
            pixel_next = s1_dest_reg;
        end else if (s1_cov_reg == COV_FULL) begin
            pixel_next = {ALPHA_OPAQUE, s1_src_reg[23:0]};
        end else begin
            pixel_next = {ALPHA_OPAQUE, chan[2], chan[1], chan[0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[2]) begin
            pixel_reg <= pixel_next;
            cov_reg   <= s1_cov_reg;
        end
    end

    assign out_pixel = pixel_reg;
    assign out_cov   = cov_reg;

endmodule

// ----- sv/rounded_corner_coverage_blend_top.sv -----
// an accepted s_ beat passes five distance stages and two blend stages before it leaves as its m_ beat
// throughput: one pixel per cycle while m_tready stays high; each stage has its own valid and moves on ready
// the rom read in stage four is one registered port shared by nothing else
// reset: synchronous active-low aresetn empties the pipeline and zeroes the config registers
// the square root rom is constant and needs no clearing after reset
module rounded_corner_coverage_blend_top
    import rcb_pkg::*;
#(
    parameter int MAX_CORNER_RADIUS = RCB_MAX_CORNER_RADIUS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // apb config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // pixel in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pixel_x[13:0], pixel_y[27:14], dest_pixel[59:28], source_pixel[91:60], zero[95:92]
    input  logic [S_DATA_W-1:0]   s_tdata,
    // pixel out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_pixel[31:0], coverage[39:32]
    output logic [M_DATA_W-1:0]   m_tdata
);

    logic signed [COORD_W-1:0] rect_left_reg, rect_top_reg;
    logic [SIZE_W-1:0]         rect_width_reg, rect_height_reg;
    logic [RADIUS_W-1:0]       corner_radius_reg;
    rcb_cfg_t                  cfg;
    rcb_reg_t                  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = rcb_reg_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rect_left_reg     <= '0;
            rect_top_reg      <= '0;
            rect_width_reg    <= '0;
            rect_height_reg   <= '0;
            corner_radius_reg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_RECT_LEFT:     rect_left_reg     <= signed'(pwdata[COORD_W-1:0]);
                REG_RECT_TOP:      rect_top_reg      <= signed'(pwdata[COORD_W-1:0]);
                REG_RECT_WIDTH:    rect_width_reg    <= pwdata[SIZE_W-1:0];
                REG_RECT_HEIGHT:   rect_height_reg   <= pwdata[SIZE_W-1:0];
                REG_CORNER_RADIUS: corner_radius_reg <= pwdata[RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RECT_LEFT:     prdata = {18'b0, rect_left_reg};
            REG_RECT_TOP:      prdata = {18'b0, rect_top_reg};
            REG_RECT_WIDTH:    prdata = {19'b0, rect_width_reg};
            REG_RECT_HEIGHT:   prdata = {19'b0, rect_height_reg};
            REG_CORNER_RADIUS: prdata = {28'b0, corner_radius_reg};
            default:           prdata = '0;
        endcase
    end

    assign cfg.rect_left     = rect_left_reg;
    assign cfg.rect_top      = rect_top_reg;
    assign cfg.rect_width    = rect_width_reg;
    assign cfg.rect_height   = rect_height_reg;
    assign cfg.corner_radius = corner_radius_reg;

    logic signed [COORD_W-1:0] pixel_x, pixel_y;
    logic [PIXEL_W-1:0]        dest_pixel, source_pixel;

    assign pixel_x      = signed'(s_tdata[13:0]);
    assign pixel_y      = signed'(s_tdata[27:14]);
    assign dest_pixel   = s_tdata[59:28];
    assign source_pixel = s_tdata[91:60];

    logic               dist_valid, dist_ready;
    logic [COV_W-1:0]   dist_cov;
    logic [PIXEL_W-1:0] dist_dest, dist_src;
    logic [PIXEL_W-1:0] out_pixel;
    logic [COV_W-1:0]   coverage;

    rcb_dist #(
        .MAX_CORNER_RADIUS (MAX_CORNER_RADIUS)
    ) u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_x      (pixel_x),
        .in_y      (pixel_y),
        .in_dest   (dest_pixel),
        .in_src    (source_pixel),
        .out_valid (dist_valid),
        .out_ready (dist_ready),
        .out_cov   (dist_cov),
        .out_dest  (dist_dest),
        .out_src   (dist_src)
    );

    rcb_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dist_valid),
        .in_ready  (dist_ready),
        .in_cov    (dist_cov),
        .in_dest   (dist_dest),
        .in_src    (dist_src),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pixel (out_pixel),
        .out_cov   (coverage)
    );

    assign m_tdata = {coverage, out_pixel};

endmodule

// ----- sv/rcb_checker.sv -----
// port level checks of the coverage blend, bound to the top level
`include "rounded_corner_coverage_blend_top_assert.svh"

module rcb_checker
    import rcb_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  pready,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [S_DATA_W-1:0]   s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_DATA_W-1:0]   m_tdata
);

    // a stalled result beat stays and holds its data
    `RCB_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `RCB_ASSERT_NXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))

    // input only backs up when the whole pipe is full behind a stalled output
    `RCB_ASSERT_IMP(a_in_stall_cause, aclk, aresetn, !s_tready, m_tvalid && !m_tready)

    // coverage is zero, full, or a ramp step of 32
    `RCB_ASSERT_IMP(a_cov_legal, aclk, aresetn, m_tvalid, (m_tdata[39:32] == 8'hFF) || (m_tdata[36:32] == 5'd0))

    // any drawn pixel comes out opaque
    `RCB_ASSERT_IMP(a_alpha_opaque, aclk, aresetn, m_tvalid && (m_tdata[39:32] != 8'h00), m_tdata[31:24] == 8'hFF)

endmodule

bind rounded_corner_coverage_blend_top rcb_checker u_rcb_checker (.*);

// ----- tb/tb_top.sv -----
// self-checking testbench for the rounded corner coverage blend: apb setup, pixel stream, result check
module tb_top;
    import rcb_pkg::*;

    localparam int CORNER_SPAN = 2 * RCB_MAX_CORNER_RADIUS;
    localparam int ROOT_DEPTH  = 2 * CORNER_SPAN * CORNER_SPAN + 1;
    localparam int PIPE_SLACK  = 16;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [PIXEL_W-1:0]         src;
        logic [PIXEL_W-1:0]         dst;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  x;
    } pixel_beat_t;

    typedef struct packed {
        logic [COV_W-1:0]   coverage;
        logic [PIXEL_W-1:0] out_pixel;
    } blend_beat_t;

    typedef enum int {
        PACE_FULL,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } pace_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    rounded_corner_coverage_blend_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    logic [ROOT_W-1:0] root_rom [0:ROOT_DEPTH-1];
    rcb_cfg_t          rect_cfg = '0;
    pixel_beat_t       pending_pixels[$];
    blend_beat_t       expected_blends[$];
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_stall_pct = 0;
    int                cycle_count = 0;
    int                mismatch_count = 0;
    int                pixels_in = 0;
    int                full_hits = 0;
    int                edge_hits = 0;
    int                miss_hits = 0;
    int                setting_count = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    endtask

    // signed distance in eighth pixels, then coverage and the opaque blend
    function automatic blend_beat_t predict_blend(input pixel_beat_t pix);
        blend_beat_t res;
        longint      left, top, w, h, r, ax, ay, qx, qy, k, edge_dist;
        int          cov, ch, s, d;
        left = $signed(rect_cfg.rect_left);
        top  = $signed(rect_cfg.rect_top);
        w    = rect_cfg.rect_width;
        h    = rect_cfg.rect_height;
        r    = rect_cfg.corner_radius;
        if (r > RCB_MAX_CORNER_RADIUS) r = RCB_MAX_CORNER_RADIUS;
        ax = 2 * longint'(pix.x) + 1 - (2 * left + w);
        ay = 2 * longint'(pix.y) + 1 - (2 * top + h);
        if (ax < 0) ax = -ax;
        if (ay < 0) ay = -ay;
        qx = ax - (w - 2 * r);
        qy = ay - (h - 2 * r);
        if (qx <= 0 && qy <= 0) begin
            edge_dist = ((qx > qy) ? qx : qy) * 4 - r * 8;
        end else begin
            if (qx < 0) qx = 0;
            if (qy < 0) qy = 0;
            if (qx >= ROOT_DEPTH || qy >= ROOT_DEPTH) begin
                edge_dist = CORNER_SPAN * 8;
            end else begin
                k = qx * qx + qy * qy;
                if (k >= ROOT_DEPTH) edge_dist = CORNER_SPAN * 8;
                else edge_dist = longint'(root_rom[k]) - r * 8;
            end
        end
        if (edge_dist <= -4) cov = 255;
        else if (edge_dist >= 4) cov = 0;
        else cov = int'(4 - edge_dist) * 32;
        res.coverage = COV_W'(cov);
        if (cov == 0) begin
            res.out_pixel = pix.dst;
        end else if (cov == 255) begin
            res.out_pixel = {ALPHA_OPAQUE, pix.src[23:0]};
        end else begin
            res.out_pixel[31:24] = ALPHA_OPAQUE;
            for (ch = 0; ch < 3; ch++) begin
                s = pix.src[8*ch +: 8];
                d = pix.dst[8*ch +: 8];
                res.out_pixel[8*ch +: 8] = 8'((s * cov + d * (255 - cov) + 127) / 255);
            end
        end
        return res;
    endfunction

    // driver: next pixel beat once the current one is taken
    always @(posedge aclk) begin : pixel_driver
        pixel_beat_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_pixels.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= S_DATA_W'(nxt);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: predict on each accepted input beat, check each accepted output beat
    always @(posedge aclk) begin : blend_monitor
        blend_beat_t want;
        blend_beat_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want = predict_blend(pixel_beat_t'(s_tdata[S_DATA_W-5:0]));
                expected_blends.push_back(want);
                pixels_in++;
                if (want.coverage == COV_FULL) full_hits++;
                else if (want.coverage == COV_NONE) miss_hits++;
                else edge_hits++;
            end
            if (m_tvalid && m_tready) begin
                got = blend_beat_t'(m_tdata);
                if (expected_blends.size() == 0) begin
                    report_mismatch("unexpected beat", got.out_pixel, '0);
                end else begin
                    want = expected_blends.pop_front();
                    if (got.out_pixel !== want.out_pixel)
                        report_mismatch("out_pixel", got.out_pixel, want.out_pixel);
                    if (got.coverage !== want.coverage)
                        report_mismatch("coverage", 32'(got.coverage), 32'(want.coverage));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input rcb_reg_t idx, input logic [APB_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RECT_LEFT:     rect_cfg.rect_left     = value[COORD_W-1:0];
            REG_RECT_TOP:      rect_cfg.rect_top      = value[COORD_W-1:0];
            REG_RECT_WIDTH:    rect_cfg.rect_width    = value[SIZE_W-1:0];
            REG_RECT_HEIGHT:   rect_cfg.rect_height   = value[SIZE_W-1:0];
            REG_CORNER_RADIUS: rect_cfg.corner_radius = value[RADIUS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_rect(input int left, input int top, input int w, input int h,
                            input int r);
        write_reg(REG_RECT_LEFT, APB_DATA_W'(left & 32'h3FFF));
        write_reg(REG_RECT_TOP, APB_DATA_W'(top & 32'h3FFF));
        write_reg(REG_RECT_WIDTH, APB_DATA_W'(w));
        write_reg(REG_RECT_HEIGHT, APB_DATA_W'(h));
        write_reg(REG_CORNER_RADIUS, APB_DATA_W'(r));
        setting_count++;
    endtask

    task automatic set_pace(input pace_t pace);
        case (pace)
            PACE_FULL:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            PACE_SEND_IDLE:  begin send_idle_pct = 73; recv_stall_pct = 0;  end
            PACE_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 73; end
            default:         begin send_idle_pct = 13; recv_stall_pct = 13; end
        endcase
    endtask

    task automatic push_pixel(input int x, input int y, input logic [31:0] dst,
                              input logic [31:0] src);
        pixel_beat_t pix;
        pix.x   = COORD_W'(x);
        pix.y   = COORD_W'(y);
        pix.dst = dst;
        pix.src = src;
        pending_pixels.push_back(pix);
    endtask

    // sender holds off until the pipe is empty, then lets it settle
    // checked on the falling edge so the driver and monitor updates have landed
    task automatic drain();
        while (pending_pixels.size() != 0 || s_tvalid || expected_blends.size() != 0)
            @(negedge aclk);
        repeat (PIPE_SLACK) @(posedge aclk);
    endtask

    // mostly near an edge or inside the span, sometimes anywhere
    function automatic int pick_coord(input int lo, input int span);
        case ($urandom_range(9))
            0, 1:       return lo + int'($urandom_range(24)) - 12;
            2, 3:       return lo + span + int'($urandom_range(24)) - 12;
            4, 5, 6, 7: return lo + int'($urandom_range(span));
            default:    return int'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int v;
        int left, top, w, h, r;
        v = 0;
        for (int k = 0; k < ROOT_DEPTH; k++) begin
            while ((2 * v + 1) * (2 * v + 1) <= 64 * k) v++;
            root_rom[k] = ROOT_W'(v);
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: straight edges, corners, far outside and coordinate extremes
        set_pace(PACE_FULL);
        set_rect(-4, -3, 20, 12, 5);
        push_pixel(6, 3, 32'h0000_0000, 32'hFFFF_FFFF);
        push_pixel(-4, 3, 32'h1234_5678, 32'h9ABC_DEF0);
        push_pixel(15, 3, 32'hFFFF_FFFF, 32'h0000_0000);
        push_pixel(6, -3, 32'h0000_0000, 32'hFFFF_FFFF);
        push_pixel(6, 8, 32'hFFFF_FFFF, 32'h0000_0000);
        push_pixel(-5, 3, 32'h80FF_00FF, 32'h7F00_FF00);
        push_pixel(16, 3, 32'hFFFF_FFFF, 32'h0000_0000);
        push_pixel(-4, -3, 32'h0000_0000, 32'hFFFF_FFFF);
        push_pixel(15, 8, 32'hFFFF_FFFF, 32'h0000_0000);
        push_pixel(-3, -2, 32'h00FF_FFFF, 32'hFF00_0000);
        push_pixel(-2, -3, $urandom, $urandom);
        push_pixel(-3, -1, $urandom, $urandom);
        push_pixel(-12, -11, 32'hDEAD_BEEF, 32'h0BAD_F00D);
        push_pixel(-8192, -8192, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_pixel(8191, 8191, 32'h0000_0000, 32'h0000_0000);
        push_pixel(-8192, 8191, $urandom, $urandom);
        push_pixel(8191, -8192, $urandom, $urandom);
        drain();

        // random: extreme settings first, then random rectangles, pacing rotates
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: begin left = -8192; top = -8192; w = 8191; h = 8191; r = 8;  end
                1: begin left = 8191;  top = 8191;  w = 0;    h = 0;    r = 0;  end
                2: begin left = 100;   top = -50;   w = 3;    h = 2;    r = 8;  end
                3: begin left = -20;   top = 30;    w = 40;   h = 25;   r = 15; end
                4: begin left = 0;     top = 0;     w = 1;    h = 1;    r = 1;  end
                5: begin left = -8192; top = 8191;  w = 8191; h = 0;    r = 9;  end
                default: begin
                    left = int'($signed(14'($urandom)));
                    top  = int'($signed(14'($urandom)));
                    w = ($urandom_range(3) == 0) ? int'($urandom_range(8191))
                                                 : int'($urandom_range(64));
                    h = ($urandom_range(3) == 0) ? int'($urandom_range(8191))
                                                 : int'($urandom_range(64));
                    r = ($urandom_range(4) == 0) ? int'($urandom_range(15))
                                                 : int'($urandom_range(8));
                end
            endcase
            set_pace(pace_t'(ph % 4));
            set_rect(left, top, w, h, r);
            repeat (66) begin
                push_pixel(pick_coord(left, w), pick_coord(top, h), $urandom, $urandom);
            end
            drain();
        end

        if (expected_blends.size() != 0)
            report_mismatch("results never seen", 32'(expected_blends.size()), '0);
        $display("%0d pixels over %0d rectangle settings and four pacing modes",
                 pixels_in, setting_count);
        $display("coverage mix: %0d full, %0d partial edge, %0d outside; %0d mismatches",
                 full_hits, edge_hits, miss_hits, mismatch_count);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
